// ===== rtl/core/arc_pkg.sv =====
// arc_pkg: shared types and constants of the adaptive replacement cache directory
package arc_pkg;

    localparam int FRAC_BITS = 8;
    localparam int CAP_W     = 9;
    localparam int P_W       = 17;
    localparam int CNT_W     = 32;
    localparam int IN_ADDR_W = 32;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [1:0] LIST_T1 = 2'd0;
    localparam logic [1:0] LIST_T2 = 2'd1;
    localparam logic [1:0] LIST_B1 = 2'd2;
    localparam logic [1:0] LIST_B2 = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_DIV,
        ST_ADAPT,
        ST_NEXT,
        ST_TAIL,
        ST_FREE,
        ST_TREAD,
        ST_TWAIT,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_POP,
        PH_EVICT,
        PH_FINAL,
        PH_END
    } t_phase;

endpackage

// ===== rtl/core/arc_div.sv =====
// arc_div: restoring divider, one quotient bit per cycle
module arc_div #(
    parameter int N_W = 17,
    parameter int D_W = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);

    localparam int C_W = $clog2(N_W + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [C_W-1:0] r_cnt, n_cnt;
    logic [D_W-1:0] r_rem, n_rem;
    logic [N_W-1:0] r_quo, n_quo;
    logic [D_W-1:0] r_dvs, n_dvs;
    logic [D_W:0]   rem_sh;
    logic [D_W+1:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        rem_sh = {r_rem, r_quo[N_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!trial[D_W+1]) begin
                n_rem = trial[D_W-1:0];
                n_quo = {r_quo[N_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[D_W-1:0];
                n_quo = {r_quo[N_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == C_W'(N_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/core/arc_page_replacement_core.sv =====
// arc_page_replacement_core: adaptive replacement cache directory, top level
//
// Requests arrive on the input channel (i_in_valid / o_in_stall) with a mode
// (get or search) and a block address; each request yields one result on the
// output channel (o_out_valid / i_out_stall): hit flag and the request, hit
// and get-miss counters after the update. The capacity register sits on the
// APB port at byte address 0.
// One request runs as a sequence of full passes over the 2*MAX_ENTRIES
// directory slots through one read port and one write port of the slot
// memory, one slot per cycle: a lookup pass, then up to two tail searches
// with a rank update pass each, then a free slot search for a new get miss,
// and a final update pass. After the result is registered the block
// returns to idle and takes the next request. The stall stays high for
// the whole request. After reset a clearing pass over all 2*MAX_ENTRIES
// slots empties the directory with the input stalled. A finished result
// waits in the output register while the receiver stalls; the next
// request is taken meanwhile, but its result waits in the done state
// until the output register is free.
module arc_page_replacement_core #(
    parameter int MAX_ENTRIES = 256,
    parameter int ADDR_BITS   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [arc_pkg::IN_ADDR_W-1:0]   i_addr,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_hit,
    output logic [arc_pkg::CNT_W-1:0]       o_request_count,
    output logic [arc_pkg::CNT_W-1:0]       o_hit_count,
    output logic [arc_pkg::CNT_W-1:0]       o_miss_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arc_pkg::PADDR_W-1:0]     paddr,
    input  logic [arc_pkg::DATA_W-1:0]      pwdata,
    output logic [arc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int DEPTH  = 2 * MAX_ENTRIES;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int SIZE_W = IDX_W + 1;
    localparam int RANK_W = IDX_W;
    localparam int META_W = 3 + RANK_W;
    localparam int AW     = (ADDR_BITS < arc_pkg::IN_ADDR_W) ? ADDR_BITS : arc_pkg::IN_ADDR_W;
    localparam int Q_W    = SIZE_W + arc_pkg::FRAC_BITS;
    localparam int CW     = (SIZE_W + 2 > arc_pkg::CAP_W + 2) ? SIZE_W + 2 : arc_pkg::CAP_W + 2;
    localparam int FW     = (Q_W + 1 > arc_pkg::P_W + 1) ? Q_W + 1 : arc_pkg::P_W + 1;
    localparam int CAP_W  = arc_pkg::CAP_W;
    localparam int P_W    = arc_pkg::P_W;
    localparam int CNT_W  = arc_pkg::CNT_W;
    localparam int PADDR_TOP = arc_pkg::PADDR_W - 1;

    logic [META_W-1:0] r_meta_mem [DEPTH];
    logic [AW-1:0]     r_addr_mem [DEPTH];

    arc_pkg::t_state r_state, n_state;
    arc_pkg::t_phase r_phase, n_phase;

    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic              r_issue_done, n_issue_done;
    logic              r_q_vld, n_q_vld;
    logic [IDX_W-1:0]  r_q_idx;
    logic [META_W-1:0] r_meta_q;
    logic [AW-1:0]     r_addr_q;

    logic              r_scan_found, n_scan_found;
    logic [IDX_W-1:0]  r_scan_idx, n_scan_idx;

    logic              r_mode, n_mode;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [1:0]        r_slot_list, n_slot_list;

    logic              r_pop_en, n_pop_en;
    logic [1:0]        r_pop_list, n_pop_list;
    logic              r_evict_en, n_evict_en;
    logic              r_evict_b2, n_evict_b2;
    logic              r_fin_move, n_fin_move;
    logic              r_fin_ins, n_fin_ins;

    logic [1:0]        r_cur_list, n_cur_list;
    logic [IDX_W-1:0]  r_tgt, n_tgt;
    logic              r_tgt_put, n_tgt_put;
    logic [1:0]        r_tgt_nl, n_tgt_nl;
    logic              r_tv, n_tv;
    logic [1:0]        r_tl, n_tl;
    logic [RANK_W-1:0] r_tr, n_tr;

    logic [SIZE_W-1:0] r_size [4];
    logic [SIZE_W-1:0] n_size [4];
    logic [P_W-1:0]    r_p, n_p;
    logic [CAP_W-1:0]  r_cap;
    logic [Q_W-1:0]    r_ratio, n_ratio;
    logic [CNT_W-1:0]  r_req, n_req;
    logic [CNT_W-1:0]  r_hits, n_hits;
    logic [CNT_W-1:0]  r_miss, n_miss;
    logic              r_hit_flag, n_hit_flag;

    logic              r_out_valid, n_out_valid;
    logic              r_out_hit, n_out_hit;
    logic [CNT_W-1:0]  r_out_req, n_out_req;
    logic [CNT_W-1:0]  r_out_hits, n_out_hits;
    logic [CNT_W-1:0]  r_out_miss, n_out_miss;

    logic              issue, scan_state, scan_last, match;
    logic [IDX_W-1:0]  rd_idx;
    logic              meta_we;
    logic [IDX_W-1:0]  wr_idx;
    logic [META_W-1:0] wd;
    logic              addr_we;
    logic              m_valid;
    logic [1:0]        m_list;
    logic [RANK_W-1:0] m_rank;
    logic              dec, inc;
    logic [SIZE_W-1:0] tail_rank;
    logic [CAP_W-1:0]  cap_eff;
    logic [CW-1:0]     len, t1b1;
    logic [FW-1:0]     t1fx, pfx, capfx, psum, ratio_fx;
    logic              evict_t1;
    logic              cfg_we;

    logic              div_start;
    logic              div_done;
    logic [Q_W-1:0]    div_dividend;
    logic [SIZE_W-1:0] div_divisor;
    logic [Q_W-1:0]    div_quot;

    arc_div #(
        .N_W (Q_W),
        .D_W (SIZE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // configuration port
    assign cfg_we = psel && penable && pwrite && pready && (paddr[PADDR_TOP] == arc_pkg::REG_CAPACITY);
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_TOP] == arc_pkg::REG_CAPACITY) ?
                    arc_pkg::DATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= arc_pkg::CAP_RESET;
        end else if (cfg_we) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // effective capacity and size sums
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CAP_W'(1);
        end else if (CW'(r_cap) > CW'(MAX_ENTRIES)) begin
            cap_eff = CAP_W'(MAX_ENTRIES);
        end else begin
            cap_eff = r_cap;
        end
        len = CW'(r_size[0]) + CW'(r_size[1]) + CW'(r_size[2]) + CW'(r_size[3]);
        t1b1 = CW'(r_size[arc_pkg::LIST_T1]) + CW'(r_size[arc_pkg::LIST_B1]);
        t1fx = FW'(r_size[arc_pkg::LIST_T1]) << arc_pkg::FRAC_BITS;
        pfx = FW'(r_p);
        capfx = FW'(cap_eff) << arc_pkg::FRAC_BITS;
        ratio_fx = FW'(r_ratio);
        psum = pfx + ratio_fx;
        evict_t1 = (r_size[arc_pkg::LIST_T1] != '0) &&
                   ((t1fx > pfx) || (r_evict_b2 && (t1fx == pfx)));
    end

    // slot memory fields
    assign m_valid   = r_meta_q[META_W-1];
    assign m_list    = r_meta_q[META_W-2:META_W-3];
    assign m_rank    = r_meta_q[RANK_W-1:0];
    assign tail_rank = r_size[r_cur_list] - 1'b1;

    assign scan_state = (r_state == arc_pkg::ST_LOOKUP) || (r_state == arc_pkg::ST_TAIL) ||
                        (r_state == arc_pkg::ST_FREE) || (r_state == arc_pkg::ST_UPDATE);
    assign issue      = scan_state && !r_issue_done;
    assign scan_last  = r_q_vld && (r_q_idx == IDX_W'(DEPTH - 1));
    assign rd_idx     = (r_state == arc_pkg::ST_TREAD) ? r_tgt : r_cnt;

    always_comb begin
        unique case (r_state)
            arc_pkg::ST_LOOKUP: match = r_q_vld && m_valid && (r_addr_q == r_addr);
            arc_pkg::ST_TAIL:   match = r_q_vld && m_valid && (m_list == r_cur_list) &&
                                        (SIZE_W'(m_rank) == tail_rank);
            arc_pkg::ST_FREE:   match = r_q_vld && !m_valid;
            default:            match = 1'b0;
        endcase
    end

    // rank rewrite of the update pass
    always_comb begin
        dec = r_tv && (m_list == r_tl) && (m_rank > r_tr);
        inc = r_tgt_put && (m_list == r_tgt_nl);
        if (r_q_idx == r_tgt) begin
            wd = r_tgt_put ? {1'b1, r_tgt_nl, {RANK_W{1'b0}}} : {1'b0, m_list, m_rank};
        end else if (m_valid) begin
            wd = {1'b1, m_list, m_rank - RANK_W'(dec) + RANK_W'(inc)};
        end else begin
            wd = r_meta_q;
        end
        if (r_state == arc_pkg::ST_CLEAR) begin
            wd = '0;
        end
    end

    always_comb begin
        meta_we = 1'b0;
        wr_idx  = r_q_idx;
        if (r_state == arc_pkg::ST_CLEAR) begin
            meta_we = 1'b1;
            wr_idx  = r_cnt;
        end else if (r_state == arc_pkg::ST_UPDATE && r_q_vld) begin
            meta_we = 1'b1;
        end
    end

    assign addr_we = (r_state == arc_pkg::ST_TREAD) && (r_phase == arc_pkg::PH_END) && r_fin_ins;

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[wr_idx] <= wd;
        end
        if (addr_we) begin
            r_addr_mem[r_tgt] <= r_addr;
        end
        r_meta_q <= r_meta_mem[rd_idx];
        r_addr_q <= r_addr_mem[rd_idx];
        r_q_idx  <= r_cnt;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_issue_done = r_issue_done;
        n_q_vld      = issue;
        n_scan_found = r_scan_found;
        n_scan_idx   = r_scan_idx;
        n_mode       = r_mode;
        n_addr       = r_addr;
        n_found      = r_found;
        n_slot       = r_slot;
        n_slot_list  = r_slot_list;
        n_pop_en     = r_pop_en;
        n_pop_list   = r_pop_list;
        n_evict_en   = r_evict_en;
        n_evict_b2   = r_evict_b2;
        n_fin_move   = r_fin_move;
        n_fin_ins    = r_fin_ins;
        n_cur_list   = r_cur_list;
        n_tgt        = r_tgt;
        n_tgt_put    = r_tgt_put;
        n_tgt_nl     = r_tgt_nl;
        n_tv         = r_tv;
        n_tl         = r_tl;
        n_tr         = r_tr;
        n_size       = r_size;
        n_p          = r_p;
        n_ratio      = r_ratio;
        n_req        = r_req;
        n_hits       = r_hits;
        n_miss       = r_miss;
        n_hit_flag   = r_hit_flag;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_hit    = r_out_hit;
        n_out_req    = r_out_req;
        n_out_hits   = r_out_hits;
        n_out_miss   = r_out_miss;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        if (issue) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == IDX_W'(DEPTH - 1)) begin
                n_issue_done = 1'b1;
            end
        end
        if (match && !r_scan_found) begin
            n_scan_found = 1'b1;
            n_scan_idx   = r_q_idx;
            if (r_state == arc_pkg::ST_LOOKUP) begin
                n_slot_list = m_list;
            end
        end

        unique case (r_state)
            arc_pkg::ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(DEPTH - 1)) begin
                    n_state = arc_pkg::ST_IDLE;
                end
            end
            arc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode       = i_mode;
                    n_addr       = i_addr[AW-1:0];
                    n_cnt        = '0;
                    n_issue_done = 1'b0;
                    n_scan_found = 1'b0;
                    n_state      = arc_pkg::ST_LOOKUP;
                end
            end
            arc_pkg::ST_LOOKUP: begin
                if (scan_last) begin
                    n_found = n_scan_found;
                    n_slot  = n_scan_idx;
                    n_state = arc_pkg::ST_DECIDE;
                end
            end
            arc_pkg::ST_DECIDE: begin
                n_req      = r_req + 1'b1;
                n_phase    = arc_pkg::PH_POP;
                n_pop_en   = 1'b0;
                n_pop_list = arc_pkg::LIST_B1;
                n_evict_en = 1'b0;
                n_evict_b2 = 1'b0;
                n_fin_move = 1'b0;
                n_fin_ins  = 1'b0;
                n_hit_flag = 1'b0;
                n_state    = arc_pkg::ST_NEXT;
                if (r_found && !r_slot_list[1]) begin
                    n_hit_flag = 1'b1;
                    n_hits     = r_hits + 1'b1;
                    n_fin_move = 1'b1;
                end else if (!r_mode) begin
                    n_miss = r_miss + 1'b1;
                    if (r_found) begin
                        n_evict_en = 1'b1;
                        n_evict_b2 = (r_slot_list == arc_pkg::LIST_B2);
                        n_fin_move = 1'b1;
                        n_ratio    = Q_W'(1) << arc_pkg::FRAC_BITS;
                        n_state    = arc_pkg::ST_ADAPT;
                        if (r_slot_list == arc_pkg::LIST_B2) begin
                            div_dividend = Q_W'(r_size[arc_pkg::LIST_B1]) << arc_pkg::FRAC_BITS;
                            div_divisor  = r_size[arc_pkg::LIST_B2];
                            if (!(r_size[arc_pkg::LIST_B2] >= r_size[arc_pkg::LIST_B1] ||
                                  r_size[arc_pkg::LIST_B2] == '0)) begin
                                div_start = 1'b1;
                                n_state   = arc_pkg::ST_DIV;
                            end
                        end else begin
                            div_dividend = Q_W'(r_size[arc_pkg::LIST_B2]) << arc_pkg::FRAC_BITS;
                            div_divisor  = r_size[arc_pkg::LIST_B1];
                            if (!(r_size[arc_pkg::LIST_B1] >= r_size[arc_pkg::LIST_B2] ||
                                  r_size[arc_pkg::LIST_B1] == '0)) begin
                                div_start = 1'b1;
                                n_state   = arc_pkg::ST_DIV;
                            end
                        end
                    end else begin
                        n_fin_ins = 1'b1;
                        if (t1b1 == CW'(cap_eff)) begin
                            n_pop_en = 1'b1;
                            if (CW'(r_size[arc_pkg::LIST_T1]) < CW'(cap_eff)) begin
                                n_pop_list = arc_pkg::LIST_B1;
                                n_evict_en = 1'b1;
                            end else begin
                                n_pop_list = arc_pkg::LIST_T1;
                            end
                        end else if (len >= CW'(cap_eff)) begin
                            n_pop_en   = (len == (CW'(cap_eff) << 1));
                            n_pop_list = arc_pkg::LIST_B2;
                            n_evict_en = 1'b1;
                        end
                    end
                end
            end
            arc_pkg::ST_DIV: begin
                if (div_done) begin
                    n_ratio = div_quot;
                    n_state = arc_pkg::ST_ADAPT;
                end
            end
            arc_pkg::ST_ADAPT: begin
                if (r_evict_b2) begin
                    n_p = (ratio_fx >= pfx) ? '0 : P_W'(pfx - ratio_fx);
                end else begin
                    n_p = (psum > capfx) ? P_W'(capfx) : P_W'(psum);
                end
                n_state = arc_pkg::ST_NEXT;
            end
            arc_pkg::ST_NEXT: begin
                n_cnt        = '0;
                n_issue_done = 1'b0;
                n_scan_found = 1'b0;
                unique case (r_phase)
                    arc_pkg::PH_POP: begin
                        n_phase = arc_pkg::PH_EVICT;
                        if (r_pop_en && r_size[r_pop_list] != '0) begin
                            n_cur_list = r_pop_list;
                            n_tgt_put  = 1'b0;
                            n_state    = arc_pkg::ST_TAIL;
                        end
                    end
                    arc_pkg::PH_EVICT: begin
                        n_phase = arc_pkg::PH_FINAL;
                        if (r_evict_en) begin
                            n_cur_list = evict_t1 ? arc_pkg::LIST_T1 : arc_pkg::LIST_T2;
                            n_tgt_put  = 1'b1;
                            n_tgt_nl   = evict_t1 ? arc_pkg::LIST_B1 : arc_pkg::LIST_B2;
                            if (r_size[n_cur_list] != '0) begin
                                n_state = arc_pkg::ST_TAIL;
                            end
                        end
                    end
                    arc_pkg::PH_FINAL: begin
                        n_phase = arc_pkg::PH_END;
                        if (r_fin_ins) begin
                            n_state = arc_pkg::ST_FREE;
                        end else if (r_fin_move) begin
                            n_tgt     = r_slot;
                            n_tgt_put = 1'b1;
                            n_tgt_nl  = arc_pkg::LIST_T2;
                            n_state   = arc_pkg::ST_TREAD;
                        end
                    end
                    arc_pkg::PH_END: begin
                        n_state = arc_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = arc_pkg::ST_DONE;
                    end
                endcase
            end
            arc_pkg::ST_TAIL: begin
                if (scan_last) begin
                    n_tgt   = n_scan_idx;
                    n_state = n_scan_found ? arc_pkg::ST_TREAD : arc_pkg::ST_NEXT;
                end
            end
            arc_pkg::ST_FREE: begin
                if (scan_last) begin
                    n_tgt     = n_scan_idx;
                    n_tgt_put = 1'b1;
                    n_tgt_nl  = arc_pkg::LIST_T1;
                    n_state   = n_scan_found ? arc_pkg::ST_TREAD : arc_pkg::ST_NEXT;
                end
            end
            arc_pkg::ST_TREAD: begin
                n_state = arc_pkg::ST_TWAIT;
            end
            arc_pkg::ST_TWAIT: begin
                n_tv         = m_valid;
                n_tl         = m_list;
                n_tr         = m_rank;
                n_cnt        = '0;
                n_issue_done = 1'b0;
                n_state      = arc_pkg::ST_UPDATE;
            end
            arc_pkg::ST_UPDATE: begin
                if (scan_last) begin
                    for (int j = 0; j < 4; j++) begin
                        n_size[j] = r_size[j]
                                  - SIZE_W'(r_tv && (r_tl == 2'(j)) && (r_size[j] != '0))
                                  + SIZE_W'(r_tgt_put && (r_tgt_nl == 2'(j)));
                    end
                    n_state = arc_pkg::ST_NEXT;
                end
            end
            arc_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit_flag;
                    n_out_req   = r_req;
                    n_out_hits  = r_hits;
                    n_out_miss  = r_miss;
                    n_state     = arc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= arc_pkg::ST_CLEAR;
            r_phase      <= arc_pkg::PH_POP;
            r_cnt        <= '0;
            r_issue_done <= 1'b0;
            r_q_vld      <= 1'b0;
            r_scan_found <= 1'b0;
            r_size       <= '{default: '0};
            r_p          <= '0;
            r_req        <= '0;
            r_hits       <= '0;
            r_miss       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_issue_done <= n_issue_done;
            r_q_vld      <= n_q_vld;
            r_scan_found <= n_scan_found;
            r_size       <= n_size;
            r_p          <= n_p;
            r_req        <= n_req;
            r_hits       <= n_hits;
            r_miss       <= n_miss;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx  <= n_scan_idx;
        r_mode      <= n_mode;
        r_addr      <= n_addr;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_slot_list <= n_slot_list;
        r_pop_en    <= n_pop_en;
        r_pop_list  <= n_pop_list;
        r_evict_en  <= n_evict_en;
        r_evict_b2  <= n_evict_b2;
        r_fin_move  <= n_fin_move;
        r_fin_ins   <= n_fin_ins;
        r_cur_list  <= n_cur_list;
        r_tgt       <= n_tgt;
        r_tgt_put   <= n_tgt_put;
        r_tgt_nl    <= n_tgt_nl;
        r_tv        <= n_tv;
        r_tl        <= n_tl;
        r_tr        <= n_tr;
        r_ratio     <= n_ratio;
        r_hit_flag  <= n_hit_flag;
        r_out_hit   <= n_out_hit;
        r_out_req   <= n_out_req;
        r_out_hits  <= n_out_hits;
        r_out_miss  <= n_out_miss;
    end

    assign o_in_stall      = (r_state != arc_pkg::ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_request_count = r_out_req;
    assign o_hit_count     = r_out_hits;
    assign o_miss_count    = r_out_miss;

endmodule

// ===== rtl/core/arc_chk.sv =====
// arc_chk: port-level assertions for the directory, bound to the top level
module arc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_hit,
    input logic [arc_pkg::CNT_W-1:0]     o_request_count
);

    // a request keeps the block busy
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a request is in progress");

    // results come only out of a busy block
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    // directory clear runs right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input ready before the directory clear");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_request_count) && $stable(o_hit)))
        else $error("stalled result changed");

endmodule

bind arc_page_replacement_core arc_chk u_arc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_hit           (o_hit),
    .o_request_count (o_request_count)
);

// ===== tb/arc_page_replacement_core_test.sv =====
// arc_page_replacement_core_test: self-checking testbench of the adaptive replacement cache directory
module arc_page_replacement_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 512;
    localparam int MAX_CAP = 256;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        logic        hit;
        logic [31:0] requests;
        logic [31:0] hits;
        logic [31:0] misses;
    } t_arc_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_mode;
    logic [31:0]       i_addr;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_hit;
    logic [31:0]       o_request_count;
    logic [31:0]       o_hit_count;
    logic [31:0]       o_miss_count;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [arc_pkg::PADDR_W-1:0] paddr;
    logic [arc_pkg::DATA_W-1:0]  pwdata;
    logic [arc_pkg::DATA_W-1:0]  prdata;
    logic              pready;

    arc_page_replacement_core uut (.*);

    // directory shadow
    logic [31:0]  dir_addr [SLOTS];
    bit           dir_used [SLOTS];
    logic [1:0]   dir_list [SLOTS];
    int unsigned  dir_rank [SLOTS];
    int unsigned  list_len [4];
    int unsigned  target_p;
    logic [31:0]  cnt_req, cnt_hit, cnt_miss;
    int unsigned  cap_reg;

    t_arc_result  pending_results[$];
    int           fail_count;
    bit           idle_on;
    longint       cycle_count = 0;
    int           out_hold;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned eff_capacity();
        if (cap_reg == 0) return 1;
        if (cap_reg > MAX_CAP) return MAX_CAP;
        return cap_reg;
    endfunction

    function automatic void unlink(int s);
        logic [1:0] l;
        int unsigned r;
        l = dir_list[s];
        r = dir_rank[s];
        dir_used[s] = 0;
        for (int i = 0; i < SLOTS; i++)
            if (dir_used[i] && dir_list[i] == l && dir_rank[i] > r) dir_rank[i]--;
        if (list_len[l] > 0) list_len[l]--;
    endfunction

    function automatic void push_mru(int s, logic [1:0] l);
        for (int i = 0; i < SLOTS; i++)
            if (dir_used[i] && dir_list[i] == l) dir_rank[i]++;
        dir_list[s] = l;
        dir_rank[s] = 0;
        dir_used[s] = 1;
        list_len[l]++;
    endfunction

    function automatic int pop_lru(logic [1:0] l);
        if (list_len[l] == 0) return -1;
        for (int i = 0; i < SLOTS; i++)
            if (dir_used[i] && dir_list[i] == l && dir_rank[i] == list_len[l] - 1) begin
                unlink(i);
                return i;
            end
        return -1;
    endfunction

    function automatic void demote_resident(bit from_b2);
        int unsigned t1fx;
        int v;
        t1fx = list_len[arc_pkg::LIST_T1] << arc_pkg::FRAC_BITS;
        if (list_len[arc_pkg::LIST_T1] != 0 &&
            (t1fx > target_p || (from_b2 && t1fx == target_p))) begin
            v = pop_lru(arc_pkg::LIST_T1);
            if (v >= 0) push_mru(v, arc_pkg::LIST_B1);
        end else begin
            v = pop_lru(arc_pkg::LIST_T2);
            if (v >= 0) push_mru(v, arc_pkg::LIST_B2);
        end
    endfunction

    function automatic t_arc_result predict_lookup(logic mode, logic [31:0] a);
        t_arc_result r;
        int unsigned cap, b1, b2, ratio, t1, len;
        int s, n;
        bit in_b2;
        cap = eff_capacity();
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (s < 0 && dir_used[i] && dir_addr[i] == a) s = i;
        r.hit = 0;
        cnt_req++;
        if (s >= 0 && dir_list[s] <= arc_pkg::LIST_T2) begin
            r.hit = 1;
            unlink(s);
            push_mru(s, arc_pkg::LIST_T2);
            cnt_hit++;
        end else if (!mode) begin
            cnt_miss++;
            if (s >= 0) begin
                b1 = list_len[arc_pkg::LIST_B1];
                b2 = list_len[arc_pkg::LIST_B2];
                in_b2 = (dir_list[s] == arc_pkg::LIST_B2);
                if (!in_b2) begin
                    ratio = (b1 >= b2 || b1 == 0) ? (1 << arc_pkg::FRAC_BITS)
                            : (b2 << arc_pkg::FRAC_BITS) / b1;
                    target_p += ratio;
                    if (target_p > (cap << arc_pkg::FRAC_BITS))
                        target_p = cap << arc_pkg::FRAC_BITS;
                end else begin
                    ratio = (b2 >= b1 || b2 == 0) ? (1 << arc_pkg::FRAC_BITS)
                            : (b1 << arc_pkg::FRAC_BITS) / b2;
                    target_p = (ratio >= target_p) ? 0 : target_p - ratio;
                end
                demote_resident(in_b2);
                unlink(s);
                push_mru(s, arc_pkg::LIST_T2);
            end else begin
                t1 = list_len[arc_pkg::LIST_T1];
                if (t1 + list_len[arc_pkg::LIST_B1] == cap) begin
                    if (t1 < cap) begin
                        void'(pop_lru(arc_pkg::LIST_B1));
                        demote_resident(0);
                    end else begin
                        void'(pop_lru(arc_pkg::LIST_T1));
                    end
                end else begin
                    len = list_len[0] + list_len[1] + list_len[2] + list_len[3];
                    if (len >= cap) begin
                        if (len == 2 * cap) void'(pop_lru(arc_pkg::LIST_B2));
                        demote_resident(0);
                    end
                end
                n = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (n < 0 && !dir_used[i]) n = i;
                if (n >= 0) begin
                    dir_addr[n] = a;
                    push_mru(n, arc_pkg::LIST_T1);
                end
            end
        end
        r.requests = cnt_req;
        r.hits = cnt_hit;
        r.misses = cnt_miss;
        return r;
    endfunction

    task automatic send_request(logic mode, logic [31:0] a);
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_addr <= a;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        i_in_valid <= 1'b0;
        pending_results.push_back(predict_lookup(mode, a));
    endtask

    task automatic write_capacity(int unsigned value);
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= arc_pkg::PADDR_W'(4 * arc_pkg::REG_CAPACITY);
        pwdata <= arc_pkg::DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cap_reg = value & 32'h1FF;
    endtask

    task automatic test_basic_lookup();
        send_request(1'b0, 32'h0000_0000);
        send_request(1'b0, 32'hFFFF_FFFF);
        send_request(1'b0, 32'h0000_0000);
        send_request(1'b1, 32'h1234_5678);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b1, 32'h0000_0000);
        send_request(1'b0, 32'hA5A5_5A5A);
    endtask

    task automatic test_ghost_adapt();
        // capacities 1, 2, 0 and 511: ghost hits in b1 and b2
        write_capacity(1);
        send_request(1'b0, 32'h10);
        send_request(1'b0, 32'h20);
        send_request(1'b0, 32'h10);
        send_request(1'b0, 32'h10);
        send_request(1'b0, 32'h20);
        send_request(1'b0, 32'h10);
        write_capacity(2);
        send_request(1'b0, 32'h30);
        send_request(1'b0, 32'h30);
        send_request(1'b0, 32'h40);
        send_request(1'b0, 32'h50);
        send_request(1'b0, 32'h30);
        send_request(1'b1, 32'h20);
        write_capacity(0);
        send_request(1'b0, 32'h60);
        send_request(1'b0, 32'h70);
        write_capacity(511);
        send_request(1'b0, 32'h60);
        send_request(1'b1, 32'h70);
    endtask

    task automatic test_random_phase(int unsigned cap, int n);
        logic [31:0] base;
        int unsigned span;
        logic [31:0] a;
        write_capacity(cap);
        base = $urandom();
        span = (cap == 0) ? 3 : (cap > 12 ? 40 : 3 * cap + 2);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) a = $urandom();
            else a = base + $urandom_range(0, span);
            send_request($urandom_range(0, 9) < 3, a);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold <= 0;
        end else if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            if (out_hold == 1) i_out_stall <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            out_hold <= $urandom_range(1, 6);
        end
    end

    always @(posedge i_clk) begin
        t_arc_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transfer: hit=%0d requests=%0d", o_hit, o_request_count);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0d actual %0d", e.hit, o_hit);
                    fail_count++;
                end
                if (o_request_count !== e.requests) begin
                    $error("request_count: expected %0d actual %0d", e.requests, o_request_count);
                    fail_count++;
                end
                if (o_hit_count !== e.hits) begin
                    $error("hit_count: expected %0d actual %0d", e.hits, o_hit_count);
                    fail_count++;
                end
                if (o_miss_count !== e.misses) begin
                    $error("miss_count: expected %0d actual %0d", e.misses, o_miss_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("arc_page_replacement_core_test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = 1'b0;
        i_addr = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        idle_on = 1'b1;
        out_hold = 0;
        for (int i = 0; i < SLOTS; i++) begin
            dir_used[i] = 0;
            dir_list[i] = arc_pkg::LIST_T1;
            dir_rank[i] = 0;
            dir_addr[i] = '0;
        end
        for (int l = 0; l < 4; l++) list_len[l] = 0;
        target_p = 0;
        cnt_req = '0;
        cnt_hit = '0;
        cnt_miss = '0;
        cap_reg = arc_pkg::CAP_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_lookup();
        test_ghost_adapt();
        test_random_phase(4, 70);
        test_random_phase(1, 60);
        test_random_phase(16, 80);
        test_random_phase(0, 40);
        test_random_phase(3, 70);
        test_random_phase(511, 60);
        test_random_phase(8, 60);
        test_random_phase(2, 60);
        idle_on = 1'b0;
        test_random_phase(256, 50);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("arc_page_replacement_core_test passed");
        end else begin
            $display("arc_page_replacement_core_test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/arc_pkg.sv
rtl/core/arc_div.sv
rtl/core/arc_page_replacement_core.sv
rtl/core/arc_chk.sv
tb/arc_page_replacement_core_test.sv
